// File: sv/lwts_pkg.sv
package lwts_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int TARGET_BITS = 24;
    localparam int BEST_BITS   = 11;
    // The sum never exceeds target plus one value, so one extra bit is enough.
    localparam int SUM_BITS    = TARGET_BITS + 1;
    localparam int OUT_BITS    = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OVF,
        ST_DROP
    } state_t;

endpackage

// File: sv/longest_window_with_target_sum.sv
// Longest window with target sum.
// Values enter on the s_ channel (s_tdata = value, s_tuser = first) and every
// item gives exactly one result item on the m_ channel (best length, match
// flag, overflow flag). The target sum is written on the cfg_ channel, which
// is always ready; write it only while no item is in flight.
// The window lives in a single-port-write, registered-read memory of
// WINDOW_DEPTH entries. An item that meets a window that is not full and
// whose sum stays within the target has its result valid the cycle after
// acceptance. A full window first reads back the value forced out (state
// ST_OVF), and every value removed while shrinking needs its own memory
// read (state ST_DROP) before the result is written. Each value is removed
// at most once.
// A new item is taken only when the previous one has settled and the result
// register is empty or being emptied in the same cycle. If the receiver
// stalls, the result is held and s_tready stays low.
// Reset clears the window, sum, best length and target; the memory itself
// is not cleared, since only entries inside the window are ever read.
module longest_window_with_target_sum #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lwts_pkg::TARGET_BITS-1:0]   cfg_data,   // target_sum
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lwts_pkg::VALUE_BITS-1:0]    s_tdata,    // value
    input  logic [0:0]                         s_tuser,    // first
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // best_length [10:0], match_here [11], window_overflow [12], zeros above
    output logic [lwts_pkg::OUT_BITS-1:0]      m_tdata
);
    import lwts_pkg::*;

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    logic [VALUE_BITS-1:0] window_mem [WINDOW_DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       best_reg, best_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic                   ovf_reg, ovf_next;
    logic                   fwd_reg, fwd_next;
    logic [TARGET_BITS-1:0] target_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [BEST_BITS-1:0]   out_best_reg, out_best_next;
    logic                   out_match_reg, out_match_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   mem_we;
    logic [PTR_W-1:0]       mem_wa;
    logic [VALUE_BITS-1:0]  mem_wd;
    logic                   rd_en;
    logic [PTR_W-1:0]       rd_addr;
    logic [VALUE_BITS-1:0]  rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_BITS - BEST_BITS - 2){1'b0}}, out_ovf_reg, out_match_reg,
                        out_best_reg};
    assign rd_data   = fwd_reg ? val_reg : rd_data_reg;

    always_comb
    begin
        logic                 first_in;
        logic [CNT_W-1:0]     cnt_e;
        logic [PTR_W-1:0]     ptr_e;
        logic [SUM_BITS-1:0]  sum_e;
        logic [CNT_W-1:0]     best_e;
        logic [PTR_W:0]       wr_sum;
        logic                 settle;
        logic [SUM_BITS-1:0]  sum_c;
        logic [CNT_W-1:0]     cnt_c;
        logic [PTR_W-1:0]     ptr_c;
        logic [CNT_W-1:0]     best_c;
        logic                 ovf_c;
        logic                 match;

        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        best_next      = best_reg;
        val_next       = val_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_best_next  = out_best_reg;
        out_match_next = out_match_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_wa         = ptr_reg;
        mem_wd         = val_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        first_in       = s_tuser[0];
        cnt_e          = first_in ? '0 : cnt_reg;
        ptr_e          = first_in ? '0 : ptr_reg;
        sum_e          = first_in ? '0 : sum_reg;
        best_e         = first_in ? '0 : best_reg;
        wr_sum         = (PTR_W + 1)'(ptr_e) + (PTR_W + 1)'(cnt_e);
        settle         = 1'b0;
        sum_c          = sum_reg;
        cnt_c          = cnt_reg;
        ptr_c          = ptr_reg;
        best_c         = best_reg;
        ovf_c          = ovf_reg;
        match          = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    val_next  = s_tdata;
                    best_next = best_e;
                    if (cnt_e == CNT_W'(WINDOW_DEPTH))
                    begin
                        // The slot to write holds the oldest value: read it first.
                        ovf_next   = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = ptr_e;
                        cnt_next   = cnt_e;
                        ptr_next   = ptr_e;
                        sum_next   = sum_e;
                        state_next = ST_OVF;
                    end
                    else
                    begin
                        if (wr_sum >= (PTR_W + 1)'(WINDOW_DEPTH))
                        begin
                            wr_sum = wr_sum - (PTR_W + 1)'(WINDOW_DEPTH);
                        end
                        ovf_next = 1'b0;
                        mem_we   = 1'b1;
                        mem_wa   = wr_sum[PTR_W-1:0];
                        mem_wd   = s_tdata;
                        sum_c    = sum_e + SUM_BITS'(s_tdata);
                        cnt_c    = cnt_e + CNT_W'(1);
                        ptr_c    = ptr_e;
                        best_c   = best_e;
                        ovf_c    = 1'b0;
                        settle   = 1'b1;
                    end
                end
            end
            ST_OVF:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                mem_wd = val_reg;
                sum_c  = sum_reg - SUM_BITS'(rd_data) + SUM_BITS'(val_reg);
                cnt_c  = cnt_reg;
                ptr_c  = ptr_inc(ptr_reg);
                settle = 1'b1;
            end
            ST_DROP:
            begin
                sum_c  = sum_reg - SUM_BITS'(rd_data);
                cnt_c  = cnt_reg - CNT_W'(1);
                ptr_c  = ptr_inc(ptr_reg);
                settle = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (settle)
        begin
            sum_next  = sum_c;
            cnt_next  = cnt_c;
            ptr_next  = ptr_c;
            best_next = best_c;
            if ((cnt_c != '0) && (sum_c > SUM_BITS'(target_reg)))
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_c;
                state_next = ST_DROP;
            end
            else
            begin
                match = (sum_c == SUM_BITS'(target_reg));
                if (match && (cnt_c > best_c))
                begin
                    best_next = cnt_c;
                end
                out_valid_next = 1'b1;
                out_best_next  = BEST_BITS'(best_next);
                out_match_next = match;
                out_ovf_next   = ovf_c;
                state_next     = ST_IDLE;
            end
        end

        fwd_next = rd_en && mem_we && (rd_addr == mem_wa);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            fwd_reg       <= 1'b0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        out_best_reg  <= out_best_next;
        out_match_reg <= out_match_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= window_mem[rd_addr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("Window count exceeds the depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OVF) |-> (cnt_reg == CNT_W'(WINDOW_DEPTH)) && ovf_reg)
        else $error("Overflow state entered without a full window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (state_reg == ST_DROP) && (cnt_reg == CNT_W'(1)))
        else $error("Forwarded read outside the single-entry drop case.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (state_reg == ST_IDLE))
        else $error("Result issued while the item is still settling.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(out_valid_reg && $past(state_reg) == ST_IDLE
                                     && $past(out_valid_reg) && !$past(m_tready)))
        else $error("Item accepted while the result register was held.");

endmodule
